// ----- src/kat_pkg.sv -----
`timescale 1ns / 1ps

package kat_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int LENGTH_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int NUM_KEYWORDS     = 4;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } operation_e;

  typedef enum logic [2:0] {
    KIND_IDENT    = 3'd0,
    KIND_KEYWORD  = 3'd1,
    KIND_NUMBER   = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_END      = 3'd4
  } token_kind_e;

  typedef struct packed {
    operation_e  operation;
    logic [7:0]  source_char;
  } in_item_t;

  typedef struct packed {
    token_kind_e token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  operator_char;
    logic        last_of_run;
  } out_item_t;

  // All results caused by one accepted input beat.
  typedef struct packed {
    logic      first_valid;
    out_item_t first;
    logic      second_valid;
    out_item_t second;
  } entry_t;

  localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][6] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"r", "e", "t", "u", "r", "n"}
  };

  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd2, 3'd4, 3'd5, 3'd6};

endpackage

// ----- src/kat_front.sv -----
`timescale 1ns / 1ps

module kat_front #(
  parameter int OFFSET_WIDTH = kat_pkg::OFFSET_WIDTH_DEF,
  parameter int LENGTH_WIDTH = kat_pkg::LENGTH_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kat_pkg::in_item_t in_data_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output kat_pkg::entry_t  entry_o
);
  import kat_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;
  logic [OFFSET_WIDTH-1:0] start_q, start_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic [NUM_KEYWORDS-1:0] cand_q, cand_d;

  logic                    accept;
  logic [7:0]              c;
  logic                    is_letter, is_digit, is_punct;
  logic                    pending;
  token_kind_e             flush_kind;
  logic [LENGTH_WIDTH-1:0] base_len, ext_len;
  logic [NUM_KEYWORDS-1:0] base_cand, ext_cand;
  out_item_t               flush_item;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign c          = in_data_i.source_char;

  assign is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit  = (c >= "0" && c <= "9");
  assign is_punct  = (c >= 8'd33 && c <= 8'd126) && !is_letter && !is_digit;
  assign pending   = (mode_q != MODE_IDLE);

  always_comb begin
    flush_kind = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
    if (mode_q == MODE_IDENT) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        if (cand_q[k] && len_q == LENGTH_WIDTH'(KW_LEN[k])) begin
          flush_kind = KIND_KEYWORD;
        end
      end
    end
  end

  always_comb begin
    flush_item               = '0;
    flush_item.token_kind    = flush_kind;
    flush_item.token_start   = 32'(start_q);
    flush_item.token_length  = 16'(len_q);
    flush_item.operator_char = 8'h00;
  end

  // A new identifier starts from a clean slate unless one is already open.
  assign base_len  = (mode_q == MODE_IDENT || (is_digit && mode_q == MODE_NUMBER)) ?
                     len_q : '0;
  assign base_cand = (mode_q == MODE_IDENT) ? cand_q : '1;
  assign ext_len   = (base_len == '1) ? base_len : base_len + LENGTH_WIDTH'(1);

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      ext_cand[k] = base_cand[k] && (base_len < LENGTH_WIDTH'(KW_LEN[k])) &&
                    (KW_TEXT[k][3'(base_len)] == c);
    end
  end

  always_comb begin
    mode_d   = mode_q;
    offset_d = offset_q;
    start_d  = start_q;
    len_d    = len_q;
    cand_d   = cand_q;
    entry_o  = '0;

    if (in_data_i.operation == OP_END) begin
      entry_o.first_valid         = pending;
      entry_o.first               = flush_item;
      entry_o.second_valid        = 1'b1;
      entry_o.second.token_kind   = KIND_END;
      entry_o.second.token_start  = 32'(offset_q);
      entry_o.second.token_length = '0;
      mode_d   = MODE_IDLE;
      offset_d = '0;
      start_d  = '0;
      len_d    = '0;
      cand_d   = '1;
    end else begin
      offset_d = offset_q + OFFSET_WIDTH'(1);
      if (is_letter) begin
        entry_o.first_valid = (mode_q == MODE_NUMBER);
        entry_o.first       = flush_item;
        mode_d  = MODE_IDENT;
        start_d = (mode_q == MODE_IDENT) ? start_q : offset_q;
        len_d   = ext_len;
        cand_d  = ext_cand;
      end else if (is_digit) begin
        if (mode_q == MODE_IDLE) begin
          mode_d  = MODE_NUMBER;
          start_d = offset_q;
          cand_d  = '1;
        end else if (mode_q == MODE_IDENT) begin
          cand_d = ext_cand;
        end
        len_d = ext_len;
      end else begin
        entry_o.first_valid = pending;
        entry_o.first       = flush_item;
        mode_d = MODE_IDLE;
        len_d  = '0;
        cand_d = '1;
        if (is_punct) begin
          entry_o.second_valid         = 1'b1;
          entry_o.second.token_kind    = KIND_OPERATOR;
          entry_o.second.token_start   = 32'(offset_q);
          entry_o.second.token_length  = 16'd1;
          entry_o.second.operator_char = c;
        end
      end
    end

    entry_o.first.last_of_run  = !entry_o.second_valid;
    entry_o.second.last_of_run = 1'b1;
  end

  assign push_o = accept && (entry_o.first_valid || entry_o.second_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      offset_q <= '0;
      start_q  <= '0;
      len_q    <= '0;
      cand_q   <= '1;
    end else if (accept) begin
      mode_q   <= mode_d;
      offset_q <= offset_d;
      start_q  <= start_d;
      len_q    <= len_d;
      cand_q   <= cand_d;
    end
  end

endmodule

// ----- src/kat_queue.sv -----
`timescale 1ns / 1ps

module kat_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kat_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output kat_pkg::entry_t head_o
);
  import kat_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign full_o       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/kat_back.sv -----
`timescale 1ns / 1ps

module kat_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  kat_pkg::entry_t    head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kat_pkg::out_item_t out_data_o
);
  import kat_pkg::*;

  logic      out_valid_q;
  out_item_t out_q;
  logic      sel_q;
  logic      load;
  logic      take_first;

  assign load       = !out_valid_q || !out_stall_i;
  assign take_first = !sel_q && head_i.first_valid;
  assign pop_o      = load && head_valid_i && !(take_first && head_i.second_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        sel_q <= take_first && head_i.second_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_q <= take_first ? head_i.first : head_i.second;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/keyword_aware_tokenizer_top.sv -----
// A result beat passes through the queue and then the output register before it is offered.
// One input beat per cycle while the queue is not full; the output register issues one
// result beat per cycle unless stalled; a four-entry queue absorbs items with two results.
// Reset is asynchronous and active low; it returns the scanner to idle at offset zero
// and empties the queue and the output register at once.
`timescale 1ns / 1ps

module keyword_aware_tokenizer_top #(
  parameter int OFFSET_WIDTH = kat_pkg::OFFSET_WIDTH_DEF,
  parameter int LENGTH_WIDTH = kat_pkg::LENGTH_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kat_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kat_pkg::out_item_t out_data_o
);
  import kat_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  kat_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .queue_full_i(queue_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  kat_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  kat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/keyword_aware_tokenizer_top_tb.sv -----
`timescale 1ns / 1ps

module keyword_aware_tokenizer_top_tb;
  import kat_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER
  } scan_e;

  typedef struct packed {
    logic      typed;
    in_item_t  item;
    out_item_t want;
  } directed_row_t;

  localparam int ROWS = 25;

  localparam directed_row_t DIRECTED [ROWS] = '{
    '{1'b1, '{OP_END, 8'hFF}, '{KIND_END, 32'd0, 16'd0, 8'd0, 1'b1}},
    '{1'b1, '{OP_CHAR, "!"}, '{KIND_OPERATOR, 32'd0, 16'd1, "!", 1'b1}},
    '{1'b1, '{OP_CHAR, "~"}, '{KIND_OPERATOR, 32'd1, 16'd1, "~", 1'b1}},
    '{1'b0, '{OP_CHAR, "i"}, '0},
    '{1'b0, '{OP_CHAR, "f"}, '0},
    '{1'b1, '{OP_CHAR, " "}, '{KIND_KEYWORD, 32'd2, 16'd2, 8'd0, 1'b1}},
    '{1'b0, '{OP_CHAR, "1"}, '0},
    '{1'b0, '{OP_CHAR, "2"}, '0},
    '{1'b0, '{OP_CHAR, "e"}, '0},
    '{1'b0, '{OP_CHAR, "l"}, '0},
    '{1'b0, '{OP_CHAR, "s"}, '0},
    '{1'b0, '{OP_CHAR, "e"}, '0},
    '{1'b0, '{OP_CHAR, "+"}, '0},
    '{1'b0, '{OP_CHAR, "r"}, '0},
    '{1'b0, '{OP_CHAR, "e"}, '0},
    '{1'b0, '{OP_CHAR, "t"}, '0},
    '{1'b0, '{OP_CHAR, "u"}, '0},
    '{1'b0, '{OP_CHAR, "r"}, '0},
    '{1'b0, '{OP_CHAR, "n"}, '0},
    '{1'b0, '{OP_CHAR, "9"}, '0},
    '{1'b0, '{OP_CHAR, 8'h80}, '0},
    '{1'b0, '{OP_CHAR, "0"}, '0},
    '{1'b0, '{OP_END, 8'h00}, '0},
    '{1'b0, '{OP_CHAR, 8'h00}, '0},
    '{1'b1, '{OP_END, 8'h5A}, '{KIND_END, 32'd1, 16'd0, 8'd0, 1'b1}}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  string keyword_text [4] = '{"if", "else", "while", "return"};

  scan_e       scan_state = SCAN_IDLE;
  logic [31:0] next_offset = '0;
  logic [31:0] tok_start = '0;
  logic [15:0] tok_len = '0;
  logic [3:0]  kw_alive = '1;

  out_item_t beat_tokens[$];
  out_item_t expected_tokens[$];
  out_item_t want;

  int  mismatches = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;

  keyword_aware_tokenizer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] random_letter();
    string near_keyword;
    near_keyword = "efhilnorstuw";
    if ($urandom_range(1) == 0) return near_keyword.getc($urandom_range(11));
    if ($urandom_range(1) == 0) return 8'("A" + $urandom_range(25));
    return 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] random_alnum();
    if ($urandom_range(3) == 0) return 8'("0" + $urandom_range(9));
    return random_letter();
  endfunction

  task automatic add_beat_token(out_item_t tok);
    beat_tokens.insert(beat_tokens.size(), tok);
  endtask

  task automatic add_expected(out_item_t tok);
    expected_tokens.insert(expected_tokens.size(), tok);
  endtask

  task automatic clear_scan();
    scan_state = SCAN_IDLE;
    tok_len    = '0;
    kw_alive   = '1;
  endtask

  task automatic open_token(scan_e mode);
    scan_state = mode;
    tok_start  = next_offset;
    tok_len    = '0;
    kw_alive   = '1;
  endtask

  task automatic grow_token(logic [7:0] c);
    if (scan_state == SCAN_IDENT) begin
      for (int k = 0; k < 4; k++) begin
        if (!(tok_len < keyword_text[k].len() && keyword_text[k].getc(tok_len) == c)) begin
          kw_alive[k] = 1'b0;
        end
      end
    end
    if (tok_len != '1) tok_len++;
  endtask

  task automatic close_token();
    token_kind_e kind;
    if (scan_state != SCAN_IDLE) begin
      kind = (scan_state == SCAN_NUMBER) ? KIND_NUMBER : KIND_IDENT;
      if (scan_state == SCAN_IDENT) begin
        for (int k = 0; k < 4; k++) begin
          if (kw_alive[k] && tok_len == keyword_text[k].len()) kind = KIND_KEYWORD;
        end
      end
      add_beat_token('{kind, tok_start, tok_len, 8'd0, 1'b0});
      clear_scan();
    end
  endtask

  task automatic tokenize_beat(in_item_t item);
    logic [7:0] c;
    c = item.source_char;
    beat_tokens.delete();
    if (item.operation == OP_END) begin
      close_token();
      add_beat_token('{KIND_END, next_offset, 16'd0, 8'd0, 1'b0});
      clear_scan();
      next_offset = '0;
      tok_start   = '0;
    end else begin
      if (is_letter(c)) begin
        if (scan_state == SCAN_NUMBER) close_token();
        if (scan_state == SCAN_IDLE) open_token(SCAN_IDENT);
        grow_token(c);
      end else if (is_digit(c)) begin
        if (scan_state == SCAN_IDLE) open_token(SCAN_NUMBER);
        grow_token(c);
      end else if (c >= 8'd33 && c <= 8'd126) begin
        close_token();
        add_beat_token('{KIND_OPERATOR, next_offset, 16'd1, c, 1'b0});
      end else begin
        close_token();
      end
      next_offset++;
    end
    if (beat_tokens.size() != 0) beat_tokens[beat_tokens.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic send_beat(in_item_t item, bit typed, out_item_t typed_token);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tokenize_beat(item);
    if (typed) begin
      add_expected(typed_token);
    end else begin
      foreach (beat_tokens[i]) add_expected(beat_tokens[i]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] c);
    send_beat('{OP_CHAR, c}, 1'b0, '0);
  endtask

  task automatic send_random_lexeme();
    int pick;
    int count;
    int variant;
    int k;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 22) begin
      k       = $urandom_range(3);
      variant = $urandom_range(3);
      count   = keyword_text[k].len() - ((variant == 1) ? 1 : 0);
      for (int i = 0; i < count; i++) begin
        c = keyword_text[k].getc(i);
        if (variant == 3 && i == 0) c = c - 8'h20;
        send_char(c);
      end
      if (variant == 2) send_char(random_alnum());
    end else if (pick < 40) begin
      send_char(random_letter());
      count = $urandom_range(7);
      repeat (count) send_char(random_alnum());
    end else if (pick < 55) begin
      count = $urandom_range(1, 6);
      repeat (count) send_char(8'("0" + $urandom_range(9)));
      if ($urandom_range(3) == 0) send_char(random_letter());
    end else if (pick < 75) begin
      do c = 8'($urandom_range(33, 126)); while (is_letter(c) || is_digit(c));
      send_char(c);
    end else if (pick < 90) begin
      case ($urandom_range(4))
        0: c = 8'h20;
        1: c = 8'h09;
        2: c = 8'h0A;
        3: c = 8'($urandom_range(32));
        default: c = 8'($urandom_range(127, 255));
      endcase
      send_char(c);
    end else if (pick < 96) begin
      send_char(8'($urandom_range(255)));
    end else begin
      send_beat('{OP_END, 8'($urandom_range(255))}, 1'b0, '0);
    end
  endtask

  initial begin
    int hold_left;
    int stall_pct;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      stall_pct = recv_idle_pct;
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token beat: kind %0d start %0d", out_data.token_kind,
               out_data.token_start);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_data.token_kind !== want.token_kind) begin
          $error("token_kind: expected %0d, got %0d", want.token_kind, out_data.token_kind);
          mismatches++;
        end
        if (out_data.token_start !== want.token_start) begin
          $error("token_start: expected %0d, got %0d", want.token_start, out_data.token_start);
          mismatches++;
        end
        if (out_data.token_length !== want.token_length) begin
          $error("token_length: expected %0d, got %0d", want.token_length,
                 out_data.token_length);
          mismatches++;
        end
        if (out_data.operator_char !== want.operator_char) begin
          $error("operator_char: expected %h, got %h", want.operator_char,
                 out_data.operator_char);
          mismatches++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_data.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int guard;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    send_idle_pct = 28;
    recv_idle_pct = 67;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < ROWS; i++) begin
      send_beat(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // The output side holds off long enough to fill the block and stall its input.
    hold_req = 1'b1;
    while (items_sent < ROWS + 340) send_random_lexeme();

    send_idle_pct = 67;
    recv_idle_pct = 28;
    while (items_sent < ROWS + 680) send_random_lexeme();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < ROWS + 1020) send_random_lexeme();

    send_beat('{OP_END, 8'h00}, 1'b0, '0);
    in_valid <= 1'b0;

    guard = 0;
    while (expected_tokens.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/kat_pkg.sv
src/kat_front.sv
src/kat_queue.sv
src/kat_back.sv
src/keyword_aware_tokenizer_top.sv
tb/keyword_aware_tokenizer_top_tb.sv
